/* src/cgm_pkg.sv */
// ----------------------------------------------------------------------------
// Collision grid package
// Shared item types, mode and direction codes for the collision grid checker.
// ----------------------------------------------------------------------------
package cgm_pkg;

   localparam int ID_BITS  = 8;
   localparam int MAX_SPAN = 16;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_MOVE   = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_WORLD    = 2'd1;
   localparam logic [1:0] KIND_SCREEN   = 2'd2;
   localparam logic [1:0] KIND_COLLIDER = 2'd3;

   localparam logic [1:0] CSR_WORLD_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_WORLD_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_SCREEN_PADDING = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] pos_x;
      logic [5:0] pos_y;
      logic [4:0] size_w;
      logic [4:0] size_h;
      logic [7:0] object_id;
      logic       is_collider;
      logic [1:0] direction;
      logic       can_exit_screen;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [1:0] block_kind;
      logic [7:0] collider_id;
      logic       last;
   } rsp_type;

   // A classified job for the back end: a run of cells along one axis or a rectangle.
   typedef struct packed {
      logic        walk;       // a cell run follows
      logic        query;      // scan for colliders instead of writing
      logic        two_pass;   // move: second run clears trailing edge
      logic        vert_run;   // run steps in y rather than x
      logic [8:0]  x0;         // signed start column
      logic [8:0]  y0;         // signed start row
      logic [8:0]  x1;         // second run start column
      logic [8:0]  y1;         // second run start row
      logic [4:0]  len;        // cells per row of the run
      logic [4:0]  rows;       // rows of the run (rectangles)
      logic        set;        // write id, otherwise clear
      logic [7:0]  id;
      logic [1:0]  kind;       // immediate result kind
      logic        allowed;
   } job_type;

endpackage

/* src/cgm_front.sv */
// ----------------------------------------------------------------------------
// Collision grid front end
// Accepts items, checks world and screen edges and builds grid jobs.
// ----------------------------------------------------------------------------
module cgm_front
   import cgm_pkg::*;
(
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   input  logic [6:0]    world_width,
   input  logic [6:0]    world_height,
   input  logic [4:0]    screen_padding,
   output logic          job_push,
   input  logic          job_full,
   output job_type       job_data
);

   localparam logic [4:0] SPAN = 5'(MAX_SPAN);

   logic [4:0] w, h;
   logic signed [8:0] px, py, maxx, maxy, to, wline, sline;
   logic       vert;
   job_type    j;

   assign req_full = job_full;
   assign job_push = req_push;
   assign job_data = j;

   always_comb begin
      w = (req_data.size_w > SPAN) ? SPAN : req_data.size_w;
      h = (req_data.size_h > SPAN) ? SPAN : req_data.size_h;
      px = 9'(req_data.pos_x);
      py = 9'(req_data.pos_y);
      maxx = px + 9'(w) - 9'sd1;
      maxy = py + 9'(h) - 9'sd1;
      vert = (req_data.direction == DIR_RIGHT) || (req_data.direction == DIR_LEFT);
      case (req_data.direction)
         DIR_UP: begin
            to = maxy + 9'sd1; wline = 9'(world_height);
            sline = 9'(world_height) - 9'(screen_padding);
         end
         DIR_DOWN: begin
            to = py - 9'sd1; wline = -9'sd1; sline = 9'(screen_padding) - 9'sd1;
         end
         DIR_RIGHT: begin
            to = maxx + 9'sd1; wline = 9'(world_width);
            sline = 9'(world_width) - 9'(screen_padding);
         end
         default: begin
            to = px - 9'sd1; wline = -9'sd1; sline = 9'(screen_padding) - 9'sd1;
         end
      endcase
      j = '0;
      j.id = req_data.object_id;
      j.allowed = 1'b1;
      j.kind = KIND_NONE;
      j.vert_run = vert;
      j.x0 = px;
      j.y0 = py;
      case (req_data.mode)
         MODE_INSERT, MODE_REMOVE: begin
            j.walk = req_data.is_collider && w != 0 && h != 0;
            j.set = (req_data.mode == MODE_INSERT);
            j.len = w;
            j.rows = h;
            j.vert_run = 1'b0;
         end
         MODE_MOVE: begin
            j.walk = req_data.is_collider && (vert ? h != 0 : w != 0);
            j.two_pass = 1'b1;
            j.set = 1'b1;
            j.len = vert ? h : w;
            j.rows = 5'd1;
            case (req_data.direction)
               DIR_UP:    begin j.y0 = maxy + 9'sd1; j.x1 = px; j.y1 = py; end
               DIR_DOWN:  begin j.y0 = py - 9'sd1; j.x1 = px; j.y1 = maxy; end
               DIR_RIGHT: begin j.x0 = maxx + 9'sd1; j.x1 = px; j.y1 = py; end
               default:   begin j.x0 = px - 9'sd1; j.x1 = maxx; j.y1 = py; end
            endcase
         end
         default: begin
            j.query = 1'b1;
            j.len = vert ? h : w;
            j.rows = 5'd1;
            if (vert) j.x0 = to; else j.y0 = to;
            if (to == wline) begin
               j.allowed = 1'b0; j.kind = KIND_WORLD;
            end else if (!req_data.can_exit_screen && to == sline) begin
               j.allowed = 1'b0; j.kind = KIND_SCREEN;
            end else begin
               j.walk = req_data.is_collider && j.len != 0;
            end
         end
      endcase
   end

endmodule

/* src/cgm_queue.sv */
// ----------------------------------------------------------------------------
// Collision grid job queue
// Two-entry queue that decouples the front end from the grid walker.
// ----------------------------------------------------------------------------
module cgm_queue
   import cgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_push,
   output logic    in_full,
   input  job_type in_data,
   output logic    out_empty,
   input  logic    out_pop,
   output job_type out_data
);

   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign in_full   = (cnt_ff == 2'd2);
   assign out_empty = (cnt_ff == 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign do_push   = in_push && !in_full;
   assign do_pop    = out_pop && !out_empty;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

/* src/cgm_back.sv */
// ----------------------------------------------------------------------------
// Collision grid back end
// Walks grid cells, writing them one per cycle or scanning them, and emits results.
// ----------------------------------------------------------------------------
module cgm_back
   import cgm_pkg::*;
#(
   parameter int GRID_X   = 64,
   parameter int GRID_Y   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   output logic       job_pop,
   input  job_type    job_data,
   input  logic [6:0] world_width,
   input  logic [6:0] world_height,
   output logic       busy,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data
);

   localparam int XB    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int YB    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int DEPTH = GRID_X * GRID_Y;
   localparam int AB    = XB + YB;
   localparam int CW    = ID_BITS + 1;
   localparam int FB    = $clog2(MAX_SPAN + 1);
   localparam int FI    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_WALK  = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_EMIT  = 4'd5;
   localparam logic [3:0] ST_LIST  = 4'd6;

   logic [3:0]      st_ff, st_in;
   logic [AB:0]     clr_ff;
   job_type         job_ff;
   logic [8:0]      cx_ff, cy_ff;
   logic [4:0]      ci_ff, ri_ff;
   logic            pass_ff;
   logic [CW-1:0]   mem [DEPTH];
   logic [CW-1:0]   rd_ff;
   logic            rd_ok_ff;
   logic [ID_BITS-1:0] found_ff [MAX_SPAN];
   logic [FB-1:0]   fcnt_ff, fk_ff;
   logic            out_v_ff;
   rsp_type         out_ff;

   logic            in_grid, wr_en, last_cell, seen, out_load;
   logic [AB-1:0]   addr, wr_addr;
   logic [CW-1:0]   wr_data;
   logic [ID_BITS-1:0] rid;

   assign busy      = (st_ff != ST_IDLE) || !job_empty;
   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;
   assign rid       = rd_ff[ID_BITS-1:0];

   always_comb begin
      in_grid = !cx_ff[8] && !cy_ff[8] && cx_ff < 9'(world_width)
                && cy_ff < 9'(world_height) && 32'(cx_ff) < GRID_X && 32'(cy_ff) < GRID_Y;
      addr = AB'(cy_ff[YB-1:0]) * AB'(GRID_X) + AB'(cx_ff[XB-1:0]);
      last_cell = (ci_ff + 5'd1 == job_ff.len) && (ri_ff + 5'd1 == job_ff.rows);
      seen = 1'b0;
      for (int k = 0; k < MAX_SPAN; k++)
         if (FB'(k) < fcnt_ff && found_ff[k] == rid) seen = 1'b1;
      wr_en = 1'b0;
      wr_addr = addr;
      wr_data = {job_ff.set && !pass_ff, job_ff.set && !pass_ff ? job_ff.id[ID_BITS-1:0]
                                                                : {ID_BITS{1'b0}}};
      if (st_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AB-1:0];
         wr_data = '0;
      end else if (st_ff == ST_WALK && !job_ff.query && in_grid) begin
         wr_en = 1'b1;
      end
      job_pop = (st_ff == ST_IDLE) && !job_empty && !out_v_ff;
      out_load = (st_ff == ST_IDLE && job_pop && !job_data.walk)
                 || (st_ff == ST_EMIT && !out_v_ff)
                 || (st_ff == ST_LIST && fcnt_ff != '0 && (!out_v_ff || rsp_pop));
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_v_ff <= 1'b0;
         fcnt_ff <= '0;
      end else begin
         if (out_load) out_v_ff <= 1'b1;
         else if (out_v_ff && rsp_pop) out_v_ff <= 1'b0;
         case (st_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == DEPTH - 1) st_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (job_pop) begin
                  job_ff <= job_data;
                  cx_ff <= job_data.x0; cy_ff <= job_data.y0;
                  ci_ff <= '0; ri_ff <= '0; pass_ff <= 1'b0;
                  fcnt_ff <= '0; fk_ff <= '0;
                  if (job_data.walk) begin
                     st_ff <= job_data.query ? ST_READ : ST_WALK;
                  end else begin
                     out_ff <= '{job_data.allowed, job_data.kind, 8'd0, 1'b1};
                  end
               end
            end
            ST_WALK, ST_CHECK: begin
               if (st_ff == ST_CHECK && rd_ok_ff && rd_ff[ID_BITS] && !seen
                   && fcnt_ff < FB'(MAX_SPAN)) begin
                  found_ff[fcnt_ff[FI-1:0]] <= rid;
                  fcnt_ff <= fcnt_ff + 1'b1;
               end
               if (last_cell) begin
                  if (job_ff.two_pass && !pass_ff) begin
                     pass_ff <= 1'b1;
                     cx_ff <= job_ff.x1; cy_ff <= job_ff.y1;
                     ci_ff <= '0; ri_ff <= '0;
                  end else if (st_ff == ST_CHECK) begin
                     st_ff <= ST_LIST;
                  end else begin
                     st_ff <= ST_EMIT;
                  end
               end else begin
                  if (ci_ff + 5'd1 == job_ff.len) begin
                     ci_ff <= '0; ri_ff <= ri_ff + 5'd1;
                     cx_ff <= job_ff.x0; cy_ff <= cy_ff + 9'd1;
                  end else begin
                     ci_ff <= ci_ff + 5'd1;
                     if (job_ff.vert_run) cy_ff <= cy_ff + 9'd1;
                     else cx_ff <= cx_ff + 9'd1;
                  end
                  if (st_ff == ST_CHECK) st_ff <= ST_READ;
               end
            end
            ST_READ: begin
               rd_ok_ff <= in_grid;
               st_ff <= ST_CHECK;
            end
            ST_EMIT: begin
               if (!out_v_ff) begin
                  out_ff <= '{1'b1, KIND_NONE, 8'd0, 1'b1};
                  st_ff <= ST_IDLE;
               end
            end
            ST_LIST: begin
               if (fcnt_ff == '0) begin
                  st_ff <= ST_EMIT;
               end else if (!out_v_ff || rsp_pop) begin
                  out_ff <= '{1'b0, KIND_COLLIDER, 8'(found_ff[fk_ff[FI-1:0]]),
                              fk_ff + 1'b1 == fcnt_ff};
                  fk_ff <= fk_ff + 1'b1;
                  if (fk_ff + 1'b1 == fcnt_ff) st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* src/collision_grid_move_checker.sv */
// ----------------------------------------------------------------------------
// Collision grid move checker
// Grid occupancy map with rectangle insert/remove, moves and move queries.
// ----------------------------------------------------------------------------
// Items with no cell walk return their result directly; writes walk every cell of the run or
// rectangle; queries read and check each scanned cell, then list colliders or report it free.
// Throughput: one item at a time; the next item is taken the cycle after the last result
// of the previous one is popped. The grid memory sets the pace of the cell walk.
// After reset a clearing pass writes every grid cell to empty;
// an item taken during it waits in the job queue.
module collision_grid_move_checker
   import cgm_pkg::*;
#(
   parameter int GRID_X   = 64,
   parameter int GRID_Y   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  req_type    req_data,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   logic [6:0] world_width_ff, world_height_ff;
   logic [4:0] screen_padding_ff;
   logic       fr_push, fr_full, q_full, q_empty, q_pop, busy, clearing;
   job_type    fr_job, q_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         world_width_ff <= 7'd64;
         world_height_ff <= 7'd64;
         screen_padding_ff <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WORLD_WIDTH:    world_width_ff <= csr_data;
            CSR_WORLD_HEIGHT:   world_height_ff <= csr_data;
            CSR_SCREEN_PADDING: screen_padding_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // One item in flight; a new item waits until results are delivered.
   logic inflight_ff;
   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= 1'b0;
      else if (push && !full) inflight_ff <= 1'b1;
      else if (pop && !empty && rsp_data.last) inflight_ff <= 1'b0;
   end

   assign clearing = reset;
   assign full = fr_full || inflight_ff || clearing;

   cgm_front u_front (
      .req_push(push && !full), .req_full(fr_full),
      .req_data,
      .world_width(world_width_ff), .world_height(world_height_ff),
      .screen_padding(screen_padding_ff),
      .job_push(fr_push), .job_full(q_full), .job_data(fr_job)
   );

   cgm_queue u_queue (
      .clock, .reset,
      .in_push(fr_push), .in_full(q_full), .in_data(fr_job),
      .out_empty(q_empty), .out_pop(q_pop), .out_data(q_job)
   );

   cgm_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y))
   u_back (
      .clock, .reset,
      .job_empty(q_empty), .job_pop(q_pop), .job_data(q_job),
      .world_width(world_width_ff), .world_height(world_height_ff),
      .busy,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) (pop && !empty) |-> busy || inflight_ff)
      else $error("result popped with no item in flight");
   assert property (@(posedge clock) disable iff (reset) (push && !full) |=> full)
      else $error("second item accepted while one is in flight");
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_data))
      else $error("waiting result changed");
`endif

endmodule
